// ===== design/itf_pkg.sv =====
// ----------------------------------------------------------------------------
// itf_pkg: shared types and constants for the integer to text formatter
// Request/result structs, sequencer states, character codes and the
// reciprocal used for the divide-by-ten step.
// ----------------------------------------------------------------------------
package itf_pkg;

  // default ceiling on the padded text length
  localparam int MAX_CHARS_DEF = 32;

  // digit buffer: a 32-bit value has at most ten decimal digits
  localparam int DIG_SLOTS = 10;
  localparam int DIG_W     = 4;
  localparam int DIG_BITS  = DIG_SLOTS * DIG_W;

  // floor(x / 10) == (x * RECIP10) >> RECIP_SHIFT for every 32-bit x
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  // pad flag and length modifier codes
  localparam logic [1:0] PAD_SPACE = 2'd0;
  localparam logic [1:0] PAD_ZERO  = 2'd1;
  localparam logic [1:0] LEN_NONE  = 2'd0;

  // character codes
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [7:0] DIGIT_CHARS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  // one formatting request
  typedef struct packed {
    logic [31:0] value;
    logic        hex_base;
    logic        signed_mode;
    logic [1:0]  pad_flag;
    logic [7:0]  min_width;
    logic [7:0]  precision;
    logic [1:0]  length_mod;
  } fmt_req_t;

  // one emitted character
  typedef struct packed {
    logic [7:0] char_out;
    logic       error;
    logic       last;
  } fmt_res_t;

  // controls into the shared divide unit
  typedef struct packed {
    logic load;
    logic hex;
  } divu_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIGIT,
    ST_EMIT,
    ST_ERR
  } fmt_state_t;

  // ASCII for one digit nibble
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return DIGIT_CHARS[d];
  endfunction

endpackage

// ===== design/itf_divu.sv =====
// ----------------------------------------------------------------------------
// itf_divu: shared divide-by-base unit
// Takes a value on load, registers it with its product by the reciprocal of
// ten, and presents quotient and remainder for base 10 or base 16 next cycle.
// ----------------------------------------------------------------------------
module itf_divu (
  input  logic                 clk,
  input  itf_pkg::divu_ctl_t   ctl_i,
  input  logic [31:0]          x_i,
  output logic [31:0]          quot_o,
  output logic [3:0]           rem_o
);

  logic [31:0] x_r;
  logic [63:0] prod_r;
  logic        hex_r;

  logic [63:0] prod_nxt;
  logic [31:0] quot_dec;
  logic [31:0] times_ten;

  // reciprocal multiply, registered
  assign prod_nxt = 64'(x_i) * 64'(itf_pkg::RECIP10);

  always_ff @(posedge clk) begin
    if (ctl_i.load) begin
      x_r    <= x_i;
      prod_r <= prod_nxt;
      hex_r  <= ctl_i.hex;
    end
  end

  // quotient and remainder; the remainder fits in a nibble
  assign quot_dec  = 32'(prod_r >> itf_pkg::RECIP_SHIFT);
  assign times_ten = (quot_dec << 3) + (quot_dec << 1);

  always_comb begin
    if (hex_r) begin
      quot_o = {4'd0, x_r[31:4]};
      rem_o  = x_r[3:0];
    end else begin
      quot_o = quot_dec;
      rem_o  = x_r[3:0] - times_ten[3:0];
    end
  end

endmodule

// ===== design/integer_to_text_formatter.sv =====
// ----------------------------------------------------------------------------
// integer_to_text_formatter: 32-bit integer to ASCII text
// Formats one value in decimal or lower-case hex, with optional sign, and
// pads it to a minimum width. Characters leave most significant first.
//
//   channel  | ports                     | handshake
//   ---------+---------------------------+-------------------------------
//   request  | start, busy, in_req       | taken when start && !busy
//   result   | out_valid, out_res        | one-cycle strobe, no back-pressure
//
// One digit per cycle from the shared reciprocal multiplier: up to ten digits
// for decimal, eight for hex, then one cycle per character, max(text, width)
// characters in all, the width being capped at the default ceiling of 32
// characters; an unsupported request gets a single error result instead.
// Reset is synchronous, active low, and returns the sequencer to idle.
// busy stays high until the last character has been registered out.
// ----------------------------------------------------------------------------
module integer_to_text_formatter #(
  parameter int MAX_CHARS = itf_pkg::MAX_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  itf_pkg::fmt_req_t in_req,
  output logic              out_valid,
  output itf_pkg::fmt_res_t out_res
);

  localparam int CW = $clog2(MAX_CHARS + 1);

  itf_pkg::fmt_state_t state_r, state_nxt;

  logic                        out_valid_r, out_valid_nxt;
  itf_pkg::fmt_res_t           out_res_r, out_res_nxt;
  logic                        neg_r, neg_nxt;
  logic                        zpad_r, zpad_nxt;
  logic                        hex_r, hex_nxt;
  logic [CW-1:0]               width_r, width_nxt;
  logic [CW-1:0]               pad_r, pad_nxt;
  logic [3:0]                  ndig_r, ndig_nxt;
  logic [itf_pkg::DIG_BITS-1:0] dig_r, dig_nxt;

  logic                        req_err;
  logic                        req_neg;
  logic [31:0]                 req_mag;
  logic [CW-1:0]               req_width;
  logic [3:0]                  text_len;
  logic                        last_char;

  itf_pkg::divu_ctl_t          divu_ctl;
  logic [31:0]                 divu_x;
  logic [31:0]                 quot;
  logic [3:0]                  rem;

  // request decode
  assign req_err = (in_req.precision != 8'd0) ||
                   (in_req.length_mod != itf_pkg::LEN_NONE) ||
                   in_req.pad_flag[1];
  assign req_neg = in_req.signed_mode && in_req.value[31];
  assign req_mag = req_neg ? (32'd0 - in_req.value) : in_req.value;
  assign req_width = (in_req.min_width > 8'(MAX_CHARS)) ? CW'(MAX_CHARS)
                                                        : CW'(in_req.min_width);

  // text length once the current digit is stored
  assign text_len  = ndig_r + 4'd1 + {3'd0, neg_r};
  assign last_char = (pad_r == '0) && !neg_r && (ndig_r == 4'd1);

  // shared divide unit; the base is held for the whole request
  assign divu_ctl.load = ((state_r == itf_pkg::ST_IDLE) && start && !req_err) ||
                         ((state_r == itf_pkg::ST_DIGIT) && (quot != 32'd0));
  assign divu_ctl.hex  = (state_r == itf_pkg::ST_IDLE) ? in_req.hex_base : hex_r;
  assign divu_x        = (state_r == itf_pkg::ST_IDLE) ? req_mag : quot;

  itf_divu u_divu (
    .clk    (clk),
    .ctl_i  (divu_ctl),
    .x_i    (divu_x),
    .quot_o (quot),
    .rem_o  (rem)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      itf_pkg::ST_IDLE: begin
        if (start) state_nxt = req_err ? itf_pkg::ST_ERR : itf_pkg::ST_DIGIT;
      end
      itf_pkg::ST_DIGIT: begin
        if (quot == 32'd0) state_nxt = itf_pkg::ST_EMIT;
      end
      itf_pkg::ST_EMIT: begin
        if (last_char) state_nxt = itf_pkg::ST_IDLE;
      end
      itf_pkg::ST_ERR: begin
        state_nxt = itf_pkg::ST_IDLE;
      end
      default: state_nxt = itf_pkg::ST_IDLE;
    endcase
  end

  // datapath and result register
  always_comb begin
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    neg_nxt       = neg_r;
    zpad_nxt      = zpad_r;
    hex_nxt       = hex_r;
    width_nxt     = width_r;
    pad_nxt       = pad_r;
    ndig_nxt      = ndig_r;
    dig_nxt       = dig_r;
    unique case (state_r)
      itf_pkg::ST_IDLE: begin
        if (start) begin
          neg_nxt   = req_neg;
          zpad_nxt  = (in_req.pad_flag == itf_pkg::PAD_ZERO);
          hex_nxt   = in_req.hex_base;
          width_nxt = req_width;
          ndig_nxt  = 4'd0;
        end
      end
      itf_pkg::ST_DIGIT: begin
        // newest digit enters at the top, so the most significant ends there
        dig_nxt  = {rem, dig_r[itf_pkg::DIG_BITS-1:itf_pkg::DIG_W]};
        ndig_nxt = ndig_r + 4'd1;
        if (quot == 32'd0) begin
          pad_nxt = (width_r > CW'(text_len)) ? (width_r - CW'(text_len)) : '0;
        end
      end
      itf_pkg::ST_EMIT: begin
        out_valid_nxt        = 1'b1;
        out_res_nxt.error    = 1'b0;
        out_res_nxt.last     = last_char;
        if (pad_r != '0) begin
          out_res_nxt.char_out = zpad_r ? itf_pkg::CH_ZERO : itf_pkg::CH_SPACE;
          pad_nxt              = pad_r - CW'(1);
        end else if (neg_r) begin
          out_res_nxt.char_out = itf_pkg::CH_MINUS;
          neg_nxt              = 1'b0;
        end else begin
          out_res_nxt.char_out =
            itf_pkg::digit_char(dig_r[itf_pkg::DIG_BITS-1 -: itf_pkg::DIG_W]);
          dig_nxt              = dig_r << itf_pkg::DIG_W;
          ndig_nxt             = ndig_r - 4'd1;
        end
      end
      itf_pkg::ST_ERR: begin
        out_valid_nxt        = 1'b1;
        out_res_nxt.char_out = itf_pkg::CH_NUL;
        out_res_nxt.error    = 1'b1;
        out_res_nxt.last     = 1'b1;
      end
      default: out_valid_nxt = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    neg_r     <= neg_nxt;
    zpad_r    <= zpad_nxt;
    hex_r     <= hex_nxt;
    width_r   <= width_nxt;
    pad_r     <= pad_nxt;
    ndig_r    <= ndig_nxt;
    dig_r     <= dig_nxt;
  end

  assign busy      = (state_r != itf_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // checks
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.error |-> out_res.last)
    else $error("error result not marked last");

  a_mid_keeps_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.last |-> busy)
    else $error("sequencer idle before last character");

  a_emit_strobes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == itf_pkg::ST_EMIT) |=> out_valid)
    else $error("emit cycle without result strobe");

  a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == itf_pkg::ST_DIGIT) |-> (ndig_r < 4'(itf_pkg::DIG_SLOTS)))
    else $error("digit buffer overrun");

  a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == itf_pkg::ST_IDLE) && !$past(busy) |-> !out_valid)
    else $error("result strobe without request");

endmodule
